/* hdl/mdnt_pkg.sv */
// Shared types, constants and field layout of the mass dissimilarity neighbour test.
package mdnt_pkg;

   localparam int TREE_DEPTH = 8;
   localparam int NUM_TREES  = 128;

   localparam int TREE_W = 7;
   localparam int NODE_W = 9;
   localparam int MASS_W = 16;
   localparam int SUM_W  = 23;
   localparam int ADDR_W = TREE_W + NODE_W;
   localparam int TABLE_DEPTH = 1 << ADDR_W;

   // Highest heap index that exists in a tree of the configured depth.
   localparam int NODE_TOP = (1 << (TREE_DEPTH + 1)) - 2;

   localparam logic [SUM_W-1:0] SUM_MAX = 23'd8388480;

   // Request and response payload widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TERM = 1'b1
   } op_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_ACC  = 1'b1
   } back_state_type;

   // One classified request on its way from the front to the back.
   typedef struct packed {
      op_type              op;
      logic                tree_ok;
      logic [ADDR_W-1:0]   addr;
      logic [MASS_W-1:0]   mass;
      logic                last;
   } entry_type;

endpackage

/* hdl/mdnt_front.sv */
// Front end: takes requests, clamps node indices and finds the common ancestor.
module mdnt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mdnt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              push,
   output mdnt_pkg::entry_type               push_entry,
   input  logic                              queue_full
);
   import mdnt_pkg::*;

   localparam int PW = NODE_W + 1;   // one-based heap index width
   localparam int LW = $clog2(PW + 1);

   logic                valid_ff, valid_in;
   op_type              op_ff;
   logic [TREE_W-1:0]   tree_ff;
   logic [NODE_W-1:0]   node_a_ff, node_b_ff;
   logic [MASS_W-1:0]   mass_ff;
   logic                last_ff;
   logic                accept;
   logic [NODE_W-1:0]   ca;

   function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = n;
      if (int'(n) > NODE_TOP) r = NODE_W'(NODE_TOP);
      return r;
   endfunction

   function automatic logic [LW-1:0] msb_pos(input logic [PW-1:0] v);
      logic [LW-1:0] pos;
      pos = '0;
      for (int i = 0; i < PW; i++) begin
         if (v[i]) pos = LW'(i);
      end
      return pos;
   endfunction

   // Common ancestor by prefix alignment: in one-based heap numbering an
   // ancestor is a leading prefix of the node's binary index.
   function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] a,
                                                         input logic [NODE_W-1:0] b);
      logic [PW-1:0] p, q, x, r;
      logic [LW-1:0] lp, lq, h;
      p  = {1'b0, a} + PW'(1);
      q  = {1'b0, b} + PW'(1);
      lp = msb_pos(p);
      lq = msb_pos(q);
      if (lp > lq) p = p >> (lp - lq);
      else         q = q >> (lq - lp);
      x = p ^ q;
      h = msb_pos(x);
      if (x == '0) r = p;
      else         r = p >> ({1'b0, h} + (LW + 1)'(1));
      r = r - PW'(1);
      return r[NODE_W-1:0];
   endfunction

   assign req_tready = !valid_ff || !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = valid_ff && !queue_full;
   assign valid_in   = accept || (valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_tuser);
         tree_ff   <= req_tdata[6:0];
         node_a_ff <= clamp_node(req_tdata[15:7]);
         node_b_ff <= clamp_node(req_tdata[24:16]);
         mass_ff   <= req_tdata[40:25];
         last_ff   <= req_tlast;
      end
   end

   assign ca = common_ancestor(node_a_ff, node_b_ff);

   always_comb begin
      push_entry.op      = op_ff;
      push_entry.tree_ok = int'(tree_ff) < NUM_TREES;
      push_entry.addr    = (op_ff == OP_LOAD) ? {tree_ff, node_a_ff} : {tree_ff, ca};
      push_entry.mass    = mass_ff;
      push_entry.last    = last_ff;
   end

endmodule

/* hdl/mdnt_queue.sv */
// Two-entry queue that decouples the front end from the table and accumulator.
module mdnt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mdnt_pkg::entry_type   push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output mdnt_pkg::entry_type   head
);
   import mdnt_pkg::*;

   entry_type   slots_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

/* hdl/mdnt_back.sv */
// Back end: node mass table, saturating accumulator and result register.
module mdnt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         not_empty,
   input  mdnt_pkg::entry_type          head,
   output logic                         pop,
   input  logic [mdnt_pkg::SUM_W-1:0]   threshold,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mdnt_pkg::SUM_W-1:0]   rsp_sum,
   output logic                         rsp_flag
);
   import mdnt_pkg::*;

   logic [MASS_W-1:0]  table_mem [TABLE_DEPTH];
   logic [MASS_W-1:0]  rd_data_ff;

   back_state_type     state_ff, state_in;
   logic               last_ff, tree_ok_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic               rsp_flag_ff;

   logic               mem_we, mem_re, advance, emit;
   logic [SUM_W:0]     wide_sum;
   logic [SUM_W-1:0]   new_sum;

   // A final term waits while an earlier result is still unclaimed.
   assign advance = !(last_ff && rsp_valid_ff && !rsp_tready);
   assign emit    = (state_ff == BACK_ACC) && advance && last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (not_empty && head.op == OP_TERM) state_in = BACK_ACC;
         end
         BACK_ACC: begin
            if (advance) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop    = 1'b0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop    = not_empty;
            mem_we = not_empty && head.op == OP_LOAD && head.tree_ok;
            mem_re = not_empty && head.op == OP_TERM;
         end
         BACK_ACC: begin
            pop = 1'b0;
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[head.addr] <= head.mass;
      if (mem_re) rd_data_ff <= table_mem[head.addr];
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         last_ff    <= head.last;
         tree_ok_ff <= head.tree_ok;
      end
   end

   always_comb begin
      wide_sum = {1'b0, sum_ff} + (SUM_W + 1)'(rd_data_ff);
      if (!tree_ok_ff)                      new_sum = sum_ff;
      else if (wide_sum > {1'b0, SUM_MAX})  new_sum = SUM_MAX;
      else                                  new_sum = wide_sum[SUM_W-1:0];

      sum_in = sum_ff;
      if (state_ff == BACK_ACC && advance) sum_in = last_ff ? '0 : new_sum;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sum_ff  <= new_sum;
         rsp_flag_ff <= (new_sum <= threshold);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_flag   = rsp_flag_ff;

endmodule

/* hdl/mass_dissimilarity_neighbor_test_unit.sv */
// Top level of the mass dissimilarity neighbour test.
// A load request (tuser 0) writes one node mass into the table at tree, node_a; a term
// request (tuser 1) finds the lowest common ancestor of node_a and node_b, adds that
// node's mass to a saturating running sum, and on a request with tlast set returns
// the sum with a flag that is high when the sum does not exceed the threshold. Node
// indices beyond the tree depth are clamped to the last node. The front end
// registers each request and works out the ancestor from the registered nodes; a
// two-entry queue then feeds the back end, where a load writes the table and a term
// reads the table, then accumulates. One load is taken per cycle while no term is
// in progress. A term table entry that has never been loaded reads as an arbitrary
// value. There is no clearing pass after reset.
module mass_dissimilarity_neighbor_test_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tree_index[6:0], node_a[15:7], node_b[24:16], mass_value[40:25], zero fill
   input  logic [mdnt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic                              req_tuser,
   // last_term
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mass_sum[22:0], zero fill
   output logic [mdnt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_neighbor
   output logic                              rsp_tuser,
   input  logic                              csr_wen,
   input  logic [mdnt_pkg::SUM_W-1:0]        csr_wdata
);
   import mdnt_pkg::*;

   logic               push, queue_full, pop, not_empty;
   entry_type          push_entry, head;
   logic [SUM_W-1:0]   threshold_ff;
   logic [SUM_W-1:0]   rsp_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_wen) begin
         threshold_ff <= csr_wdata;
      end
   end

   mdnt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   mdnt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   mdnt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .threshold  (threshold_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sum    (rsp_sum),
      .rsp_flag   (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SUM_W){1'b0}}, rsp_sum};

endmodule
